// ===== hdl/i2cm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c master register engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned MAX_BURST_DEF     = 16;
    localparam int unsigned RECOVERY_LIMIT_DEF = 9;
    localparam int unsigned IN_W  = 32;
    localparam int unsigned OUT_W = 16;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RECOVER = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_SETUP, PH_ST_HIGH, PH_ST_FALL,
        PH_TX_LOW, PH_TX_HIGH, PH_TA_LOW, PH_TA_HIGH,
        PH_RX_LOW, PH_RX_HIGH, PH_MA_LOW, PH_MA_HIGH,
        PH_SP_LOW, PH_SP_HIGH, PH_SP_RISE, PH_RC_HIGH, PH_RC_LOW
    } t_phase;

    // one classified slot handed from front to back
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] dev;
        logic [7:0] rega;
        logic [7:0] data;
        logic [6:0] cnt;
        logic       sda;
    } t_slot;

    // one result item
    typedef struct packed {
        logic       last_byte;
        logic [7:0] rd_byte;
        logic       byte_valid;
        logic       ack_ok;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } t_res;

endpackage
`default_nettype wire

// ===== hdl/i2cm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// unpacks an input slot, clamps the read count and queues it for the sequencer
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_user,
    input  wire logic [IN_W-1:0]  i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_slot                 o_slot
);
    // two-entry queue
    t_slot r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    t_slot w_slot;
    logic [4:0] w_rc;
    logic w_push, w_pop;

    always_comb begin
        w_slot.cmd  = t_cmd'(i_user);
        w_slot.dev  = i_data[7:0];
        w_slot.rega = i_data[15:8];
        w_slot.data = i_data[23:16];
        w_rc        = i_data[28:24];
        w_slot.sda  = i_data[29];
        if (w_rc == 5'd0)
            w_slot.cnt = 7'd1;
        else if (7'(w_rc) > 7'(MAX_BURST))
            w_slot.cnt = 7'(MAX_BURST);
        else
            w_slot.cnt = 7'(w_rc);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_slot  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_slot;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/i2cm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back
// bus phase sequencer, one slot per cycle while the result stage is not stalled, with a registered result stage
// ----------------------------------------------------------------------------
module i2cm_back
    import i2cm_pkg::*;
#(
    parameter int unsigned RECOVERY_LIMIT = RECOVERY_LIMIT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_slot i_slot,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_res       o_res,
    output t_phase     o_phase
);
    t_phase r_ph, n_ph;
    logic [3:0] r_bit, n_bit;
    logic [4:0] r_byte, n_byte;
    logic [7:0] r_sh, n_sh;
    t_cmd r_cmd, n_cmd;
    logic [7:0] r_dev, n_dev, r_reg, n_reg, r_dat, n_dat;
    logic [6:0] r_rem, n_rem;
    logic [3:0] r_rcp, n_rcp;
    logic r_nack, n_nack;
    logic r_ov;
    t_res r_res, w_res;
    logic w_go;
    logic [7:0] w_tx;
    logic sda;

    assign o_ready = !r_ov || i_ready;
    assign w_go    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign o_phase = r_ph;
    assign sda     = i_slot.sda;

    always_comb begin
        case (r_byte)
            5'd0: w_tx = r_dev;
            5'd1: w_tx = r_reg;
            default: w_tx = (r_cmd == CMD_WRITE) ? r_dat : r_dev + 8'd1;
        endcase
    end

    // next state
    always_comb begin
        n_ph = r_ph; n_bit = r_bit; n_byte = r_byte; n_sh = r_sh; n_cmd = r_cmd;
        n_dev = r_dev; n_reg = r_reg; n_dat = r_dat; n_rem = r_rem;
        n_rcp = r_rcp; n_nack = r_nack;
        case (r_ph)
            PH_IDLE: if (i_slot.cmd != CMD_NONE) begin
                n_rem = i_slot.cnt; n_cmd = i_slot.cmd; n_dev = i_slot.dev;
                n_reg = i_slot.rega; n_dat = i_slot.data; n_bit = '0;
                n_byte = '0; n_sh = '0; n_nack = 1'b0; n_rcp = '0;
                n_ph = (i_slot.cmd == CMD_RECOVER) ? PH_RC_HIGH : PH_ST_SETUP;
            end
            PH_ST_SETUP: n_ph = PH_ST_HIGH;
            PH_ST_HIGH:  n_ph = PH_ST_FALL;
            PH_ST_FALL: begin
                n_sh = w_tx; n_bit = '0; n_ph = PH_TX_LOW;
            end
            PH_TX_LOW: n_ph = PH_TX_HIGH;
            PH_TX_HIGH: begin
                n_sh = {r_sh[6:0], 1'b0};
                if (r_bit == 4'd7) begin
                    n_bit = '0; n_ph = PH_TA_LOW;
                end else begin
                    n_bit = r_bit + 4'd1; n_ph = PH_TX_LOW;
                end
            end
            PH_TA_LOW: n_ph = PH_TA_HIGH;
            PH_TA_HIGH: begin
                if (sda) begin
                    n_nack = 1'b1; n_ph = PH_SP_LOW;
                end else begin
                    n_byte = r_byte + 5'd1;
                    if (r_cmd == CMD_WRITE) begin
                        if (r_byte < 5'd2) begin
                            n_ph = PH_TX_LOW;
                            n_sh = (r_byte == 5'd0) ? r_reg : r_dat;
                        end else n_ph = PH_SP_LOW;
                    end else if (r_byte == 5'd0) begin
                        n_sh = r_reg; n_ph = PH_TX_LOW;
                    end else if (r_byte == 5'd1) begin
                        n_ph = PH_ST_SETUP;
                    end else begin
                        n_sh = '0; n_bit = '0; n_ph = PH_RX_LOW;
                    end
                end
            end
            PH_RX_LOW: n_ph = PH_RX_HIGH;
            PH_RX_HIGH: begin
                n_sh = {r_sh[6:0], sda};
                if (r_bit == 4'd7) begin
                    n_bit = '0; n_ph = PH_MA_LOW;
                end else begin
                    n_bit = r_bit + 4'd1; n_ph = PH_RX_LOW;
                end
            end
            PH_MA_LOW: n_ph = PH_MA_HIGH;
            PH_MA_HIGH: begin
                if (r_rem <= 7'd1) begin
                    n_rem = '0; n_ph = PH_SP_LOW;
                end else begin
                    n_rem = r_rem - 7'd1; n_sh = '0; n_ph = PH_RX_LOW;
                end
            end
            PH_SP_LOW:  n_ph = PH_SP_HIGH;
            PH_SP_HIGH: n_ph = PH_SP_RISE;
            PH_SP_RISE: n_ph = PH_IDLE;
            PH_RC_HIGH: begin
                if (sda) n_rcp = 4'(RECOVERY_LIMIT);
                else if (r_rcp != 4'd15) n_rcp = r_rcp + 4'd1;
                n_ph = PH_RC_LOW;
            end
            PH_RC_LOW: n_ph = (r_rcp >= 4'(RECOVERY_LIMIT)) ? PH_SP_LOW : PH_RC_HIGH;
            default: n_ph = PH_IDLE;
        endcase
    end

    // outputs of this slot
    always_comb begin
        w_res = '0;
        w_res.scl_level = 1'b1; w_res.sda_release = 1'b1; w_res.busy_res = 1'b1;
        case (r_ph)
            PH_IDLE: w_res.busy_res = (i_slot.cmd != CMD_NONE);
            PH_ST_HIGH, PH_TA_HIGH, PH_RC_HIGH: ;
            PH_ST_SETUP, PH_TA_LOW, PH_RX_LOW, PH_RC_LOW: w_res.scl_level = 1'b0;
            PH_ST_FALL: w_res.sda_release = 1'b0;
            PH_TX_LOW: begin
                w_res.scl_level = 1'b0; w_res.sda_release = r_sh[7];
            end
            PH_TX_HIGH: w_res.sda_release = r_sh[7];
            PH_RX_HIGH: if (r_bit == 4'd7) begin
                w_res.byte_valid = 1'b1;
                w_res.rd_byte    = {r_sh[6:0], sda};
                w_res.last_byte  = (r_rem <= 7'd1);
            end
            PH_MA_LOW: begin
                w_res.scl_level = 1'b0; w_res.sda_release = (r_rem <= 7'd1);
            end
            PH_MA_HIGH: w_res.sda_release = (r_rem <= 7'd1);
            PH_SP_LOW: begin
                w_res.scl_level = 1'b0; w_res.sda_release = 1'b0;
            end
            PH_SP_HIGH: w_res.sda_release = 1'b0;
            PH_SP_RISE: begin
                w_res.busy_res = 1'b0; w_res.done_res = 1'b1; w_res.ack_ok = !r_nack;
            end
            default: w_res.busy_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_ov <= 1'b0; r_bit <= '0; r_byte <= '0; r_sh <= '0;
            r_cmd <= CMD_NONE; r_dev <= '0; r_reg <= '0; r_dat <= '0; r_rem <= '0;
            r_rcp <= '0; r_nack <= 1'b0;
        end else begin
            if (w_go) begin
                r_ph <= n_ph;
                r_bit <= n_bit; r_byte <= n_byte; r_sh <= n_sh; r_cmd <= n_cmd;
                r_dev <= n_dev; r_reg <= n_reg; r_dat <= n_dat; r_rem <= n_rem;
                r_rcp <= n_rcp; r_nack <= n_nack;
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // result stage data, qualified by r_ov
    always_ff @(posedge i_clk) begin
        if (w_go) r_res <= w_res;
    end
endmodule
`default_nettype wire

// ===== hdl/i2c_master_register_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_engine_unit
// i2c master register engine stepped one bus time slot per transfer
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  s_axis    in   tuser: func; tdata: dev_addr, reg_addr, wr_byte, read_count,
//                 sda_level
//  m_axis    out  tdata: scl_level, sda_release, busy_res, done_res, ack_ok,
//                 byte_valid, rd_byte; tlast: last_byte
//
// one transfer in gives one transfer out; while m_axis is not stalled
// the sustained rate is one transfer per cycle
// the path runs through the front queue, then the registered result stage
// i_rst_n is synchronous and returns the sequencer to idle with queues empty
// a stall on m_axis fills the result stage and then the two-entry queue
// before s_axis_tready drops
module i2c_master_register_engine_unit
    import i2cm_pkg::*;
#(
    parameter int unsigned MAX_BURST      = MAX_BURST_DEF,
    parameter int unsigned RECOVERY_LIMIT = RECOVERY_LIMIT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // func[1:0]
    input  wire logic [1:0]       s_axis_tuser,
    // dev_addr[7:0] reg_addr[15:8] wr_byte[23:16] read_count[28:24]
    // sda_level[29], zero padded
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // last_byte
    output logic                  m_axis_tlast,
    // scl_level, sda_release, busy_res, done_res, ack_ok, byte_valid,
    // rd_byte[13:6], zero padded
    output logic [OUT_W-1:0]      m_axis_tdata
);
    t_slot  w_slot;
    logic   w_qv, w_qr;
    t_res   w_res;
    t_phase w_ph;

    // front: unpack and queue
    i2cm_front #(.MAX_BURST(MAX_BURST)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_user(s_axis_tuser),
        .i_data(s_axis_tdata),
        .o_valid(w_qv), .i_ready(w_qr), .o_slot(w_slot)
    );

    // back: phase sequencer
    i2cm_back #(.RECOVERY_LIMIT(RECOVERY_LIMIT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_slot(w_slot),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res),
        .o_phase(w_ph)
    );

    assign m_axis_tdata = {2'b00, w_res.rd_byte, w_res.byte_valid,
                           w_res.ack_ok, w_res.done_res, w_res.busy_res,
                           w_res.sda_release, w_res.scl_level};
    assign m_axis_tlast = w_res.last_byte;

    // a finished command is never reported busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.done_res |-> !w_res.busy_res)
        else $error("done with busy");
    // ack status only shown with done
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.ack_ok |-> w_res.done_res)
        else $error("ack_ok without done");
    // the sequencer leaves the final stop slot only to idle
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ph == PH_SP_RISE && w_qv && w_qr |=> w_ph == PH_IDLE)
        else $error("stop not followed by idle");
endmodule
`default_nettype wire
